>>> rtl/core/rgb_tint_quadratic_blend_assert.svh
// Assertion macros for the tint blend block checkers.
// No dependencies; included by the checker file.
`ifndef RGB_TINT_QUADRATIC_BLEND_ASSERT_SVH
`define RGB_TINT_QUADRATIC_BLEND_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define RTBQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// antecedent in this cycle implies consequent in the next cycle
`define RTBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

>>> rtl/core/rtbq_pkg.sv
// Shared types and constants for the tint blend block.
// No dependencies; used by every module and interface of the block.
package rtbq_pkg;

   // channel and arithmetic widths
   localparam int CHAN_W     = 8;
   localparam int RAD_W      = 18;                 // p^2 + 3 t^2 <= 260100
   localparam int ROOT_W     = 9;                  // floor sqrt <= 510
   localparam int SQRT_STEPS = ROOT_W;             // one root bit per stage
   localparam int DEPTH      = SQRT_STEPS + 2;     // square, root bits, output
   localparam int TRIAL_W    = RAD_W + 2;
   localparam int CSR_IDX_W  = 2;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [RAD_W-1:0]  rad_type;
   typedef logic [ROOT_W-1:0] root_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TINT_RED   = 2'd0,
      CSR_TINT_GREEN = 2'd1,
      CSR_TINT_BLUE  = 2'd2
   } csr_index_type;

   // per-stage load strobes from the pipeline control
   typedef struct packed {
      logic [DEPTH-1:0] load;
   } pipe_ctl_type;

   // what a lane hands to the merge stage
   typedef struct packed {
      root_type root;
      chan_type pass;
      logic     bypass;
   } lane_out_type;

endpackage

>>> rtl/core/rtbq_if.sv
// Request and response channel interfaces of the tint blend block.
// Depends on rtbq_pkg.
interface rtbq_req_if;
   logic              valid;
   logic              ready;
   rtbq_pkg::chan_type in_red;
   rtbq_pkg::chan_type in_green;
   rtbq_pkg::chan_type in_blue;
   rtbq_pkg::chan_type in_alpha;

   modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rtbq_rsp_if;
   logic              valid;
   logic              ready;
   rtbq_pkg::chan_type out_red;
   rtbq_pkg::chan_type out_green;
   rtbq_pkg::chan_type out_blue;
   rtbq_pkg::chan_type out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

>>> rtl/core/rtbq_ctrl.sv
// Pipeline control: per-stage valid bits, load strobes and the alpha delay line.
// Depends on rtbq_pkg.
module rtbq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rtbq_pkg::chan_type    req_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rtbq_pkg::chan_type    rsp_alpha,
   output rtbq_pkg::pipe_ctl_type ctl
);

   logic [rtbq_pkg::DEPTH-1:0] valid_ff;
   logic [rtbq_pkg::DEPTH-1:0] valid_in;
   logic [rtbq_pkg::DEPTH-1:0] move;
   logic [rtbq_pkg::DEPTH-1:0] load;
   rtbq_pkg::chan_type         alpha_ff [0:rtbq_pkg::DEPTH-1];

   // a stage drains when it holds a request and the next stage is free or draining
   always_comb begin
      move[rtbq_pkg::DEPTH-1] = valid_ff[rtbq_pkg::DEPTH-1] & rsp_ready;
      for (int i = rtbq_pkg::DEPTH - 2; i >= 0; i--) begin
         move[i] = valid_ff[i] & (~valid_ff[i+1] | move[i+1]);
      end
   end

   assign req_ready = ~valid_ff[0] | move[0];

   always_comb begin
      load[0] = req_valid & req_ready;
      for (int i = 1; i < rtbq_pkg::DEPTH; i++) begin
         load[i] = move[i-1];
      end
      valid_in = load | (valid_ff & ~move);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // alpha rides alongside the color lanes
   always_ff @(posedge clock) begin
      if (load[0]) begin
         alpha_ff[0] <= req_alpha;
      end
      for (int i = 1; i < rtbq_pkg::DEPTH; i++) begin
         if (load[i]) begin
            alpha_ff[i] <= alpha_ff[i-1];
         end
      end
   end

   assign ctl.load  = load;
   assign rsp_valid = valid_ff[rtbq_pkg::DEPTH-1];
   assign rsp_alpha = alpha_ff[rtbq_pkg::DEPTH-1];

endmodule

>>> rtl/core/rtbq_lane.sv
// One color lane: square stage, then one pipelined stage per root bit.
// Depends on rtbq_pkg.
module rtbq_lane (
   input  logic                   clock,
   input  rtbq_pkg::pipe_ctl_type ctl,
   input  rtbq_pkg::chan_type     pix,
   input  rtbq_pkg::chan_type     tint,
   output rtbq_pkg::lane_out_type lane_out
);

   localparam int N = rtbq_pkg::SQRT_STEPS;

   rtbq_pkg::rad_type  rem_ff    [0:N];
   rtbq_pkg::root_type root_ff   [0:N];
   rtbq_pkg::chan_type pass_ff   [0:N];
   logic               bypass_ff [0:N];

   logic [2*rtbq_pkg::CHAN_W-1:0] sq_p;
   logic [2*rtbq_pkg::CHAN_W-1:0] sq_t;
   rtbq_pkg::rad_type             radicand;

   // radicand p^2 + 3 t^2
   assign sq_p     = (2*rtbq_pkg::CHAN_W)'(pix) * (2*rtbq_pkg::CHAN_W)'(pix);
   assign sq_t     = (2*rtbq_pkg::CHAN_W)'(tint) * (2*rtbq_pkg::CHAN_W)'(tint);
   assign radicand = rtbq_pkg::RAD_W'(sq_p) + rtbq_pkg::RAD_W'({sq_t, 1'b0})
                   + rtbq_pkg::RAD_W'(sq_t);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         rem_ff[0]    <= radicand;
         root_ff[0]   <= '0;
         pass_ff[0]   <= pix;
         bypass_ff[0] <= (tint == '0);
      end
   end

   // restoring square root, most significant root bit first
   for (genvar s = 1; s <= N; s++) begin : g_root
      localparam int K = N - s;

      logic [rtbq_pkg::TRIAL_W-1:0] trial;
      logic                         fits;

      assign trial = (rtbq_pkg::TRIAL_W'(root_ff[s-1]) << (K + 1))
                   + (rtbq_pkg::TRIAL_W'(1) << (2 * K));
      assign fits  = rtbq_pkg::TRIAL_W'(rem_ff[s-1]) >= trial;

      always_ff @(posedge clock) begin
         if (ctl.load[s]) begin
            rem_ff[s]    <= fits ? rem_ff[s-1] - trial[rtbq_pkg::RAD_W-1:0] : rem_ff[s-1];
            root_ff[s]   <= root_ff[s-1] | (rtbq_pkg::ROOT_W'(fits) << K);
            pass_ff[s]   <= pass_ff[s-1];
            bypass_ff[s] <= bypass_ff[s-1];
         end
      end
   end

   assign lane_out.root   = root_ff[N];
   assign lane_out.pass   = pass_ff[N];
   assign lane_out.bypass = bypass_ff[N];

endmodule

>>> rtl/core/rtbq_merge.sv
// Output stage: halves each lane's root or passes the source channel through.
// Depends on rtbq_pkg.
module rtbq_merge (
   input  logic                   clock,
   input  rtbq_pkg::pipe_ctl_type ctl,
   input  rtbq_pkg::lane_out_type red_lane,
   input  rtbq_pkg::lane_out_type green_lane,
   input  rtbq_pkg::lane_out_type blue_lane,
   output rtbq_pkg::chan_type     out_red,
   output rtbq_pkg::chan_type     out_green,
   output rtbq_pkg::chan_type     out_blue
);

   rtbq_pkg::chan_type red_ff;
   rtbq_pkg::chan_type green_ff;
   rtbq_pkg::chan_type blue_ff;

   function automatic rtbq_pkg::chan_type pick(input rtbq_pkg::lane_out_type lo);
      pick = lo.bypass ? lo.pass : lo.root[rtbq_pkg::ROOT_W-1:1];
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.load[rtbq_pkg::DEPTH-1]) begin
         red_ff   <= pick(red_lane);
         green_ff <= pick(green_lane);
         blue_ff  <= pick(blue_lane);
      end
   end

   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

>>> rtl/core/rgb_tint_quadratic_blend.sv
// Tint blend of RGBA8 pixels: takes one pixel per clock and returns one pixel per clock
// while the response side does not stall. The pipeline has eleven stages: a square stage,
// nine square-root stages that each settle one root bit, and the output register. Any
// stage that holds a bubble lets the request side keep moving while a response waits.
// Tint registers (csr index 0 red, 1 green, 2 blue) reset to zero, which passes the
// channel through; write them only while no pixel is in flight.
// Depends on rtbq_pkg, rtbq_if, rtbq_ctrl, rtbq_lane, rtbq_merge.
module rgb_tint_quadratic_blend (
   input  logic               clock,
   input  logic               reset,
   rtbq_req_if.sink           req_chan,
   rtbq_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [rtbq_pkg::CSR_IDX_W-1:0] csr_index,
   input  rtbq_pkg::chan_type csr_data
);

   rtbq_pkg::chan_type     tint_red_ff;
   rtbq_pkg::chan_type     tint_green_ff;
   rtbq_pkg::chan_type     tint_blue_ff;
   rtbq_pkg::pipe_ctl_type ctl;
   rtbq_pkg::lane_out_type red_lane;
   rtbq_pkg::lane_out_type green_lane;
   rtbq_pkg::lane_out_type blue_lane;

   // tint registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         tint_red_ff   <= '0;
         tint_green_ff <= '0;
         tint_blue_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (rtbq_pkg::csr_index_type'(csr_index))
            rtbq_pkg::CSR_TINT_RED:   tint_red_ff   <= csr_data;
            rtbq_pkg::CSR_TINT_GREEN: tint_green_ff <= csr_data;
            rtbq_pkg::CSR_TINT_BLUE:  tint_blue_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   rtbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_alpha (req_chan.in_alpha),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_alpha (rsp_chan.out_alpha),
      .ctl       (ctl)
   );

   rtbq_lane u_lane_red (
      .clock    (clock),
      .ctl      (ctl),
      .pix      (req_chan.in_red),
      .tint     (tint_red_ff),
      .lane_out (red_lane)
   );

   rtbq_lane u_lane_green (
      .clock    (clock),
      .ctl      (ctl),
      .pix      (req_chan.in_green),
      .tint     (tint_green_ff),
      .lane_out (green_lane)
   );

   rtbq_lane u_lane_blue (
      .clock    (clock),
      .ctl      (ctl),
      .pix      (req_chan.in_blue),
      .tint     (tint_blue_ff),
      .lane_out (blue_lane)
   );

   rtbq_merge u_merge (
      .clock      (clock),
      .ctl        (ctl),
      .red_lane   (red_lane),
      .green_lane (green_lane),
      .blue_lane  (blue_lane),
      .out_red    (rsp_chan.out_red),
      .out_green  (rsp_chan.out_green),
      .out_blue   (rsp_chan.out_blue)
   );

endmodule

>>> rtl/core/rtbq_checker.sv
// Port-level checks for the tint blend block, bound to the top level.
// Depends on rtbq_pkg and rgb_tint_quadratic_blend_assert.svh.
`include "rgb_tint_quadratic_blend_assert.svh"

module rtbq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rtbq_pkg::chan_type out_red,
   input rtbq_pkg::chan_type out_green,
   input rtbq_pkg::chan_type out_blue,
   input rtbq_pkg::chan_type out_alpha
);

   logic pipe_unblocked;
   logic rsp_stall;

   assign pipe_unblocked = ~rsp_valid | rsp_ready;
   assign rsp_stall      = rsp_valid & ~rsp_ready;

   // a stalled response keeps its pixel
   `RTBQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha))

   // with the output free or draining, every stage moves, so a request can enter
   `RTBQ_ASSERT_NOW(a_ready_when_unblocked, clock, reset, pipe_unblocked, req_ready)

   // reset empties the pipeline
   `RTBQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // the request side does not stall while nothing waits at the output
   `RTBQ_ASSERT_NOW(a_no_stall_idle, clock, reset, req_valid && !rsp_valid, req_ready)

endmodule

bind rgb_tint_quadratic_blend rtbq_checker u_rtbq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_red   (rsp_chan.out_red),
   .out_green (rsp_chan.out_green),
   .out_blue  (rsp_chan.out_blue),
   .out_alpha (rsp_chan.out_alpha)
);

>>> tb/tb.sv
// Self-checking testbench for rgb_tint_quadratic_blend: streams RGBA8 pixels under
// several tint settings and compares every response with a predicted tinted pixel.
// Depends on rtbq_pkg, the rtbq_req_if/rtbq_rsp_if interfaces and the block itself.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtbq_pkg::*;

   // cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 4000;
   // cycles to wait after the last response so stray extras would show up
   localparam int SETTLE_CYCLES  = DEPTH + 4;
   localparam int MAX_REPORTS    = 10;
   localparam int SEGMENTS       = 19;
   localparam int SEGMENT_ITEMS  = 50;
   // index 3 maps to no register; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNUSED = 2'd3;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } pixel_type;

   // Predicts tinted pixels and checks responses in order
   class pixel_checker;
      chan_type  tint_red;
      chan_type  tint_green;
      chan_type  tint_blue;
      pixel_type pending_pixels[$];
      int        error_count;
      int        reported;

      function new();
         tint_red    = '0;
         tint_green  = '0;
         tint_blue   = '0;
         error_count = 0;
         reported    = 0;
      endfunction

      function void set_tint(logic [CSR_IDX_W-1:0] index, chan_type value);
         unique case (index)
            CSR_TINT_RED:   tint_red   = value;
            CSR_TINT_GREEN: tint_green = value;
            CSR_TINT_BLUE:  tint_blue  = value;
            default: ;  // no register here, write is dropped
         endcase
      endfunction

      // floor(isqrt(p^2 + 3 t^2) / 2), or p itself when the tint is zero
      function chan_type blended_channel(chan_type p, chan_type t);
         int sum;
         int root;
         int trial;
         if (t == 0) return p;
         sum  = int'(p) * int'(p) + 3 * int'(t) * int'(t);
         root = 0;
         for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum) root = trial;
         end
         return chan_type'(root >> 1);
      endfunction

      function void note_request(pixel_type px);
         pixel_type tinted;
         tinted.red   = blended_channel(px.red,   tint_red);
         tinted.green = blended_channel(px.green, tint_green);
         tinted.blue  = blended_channel(px.blue,  tint_blue);
         tinted.alpha = px.alpha;
         pending_pixels.push_back(tinted);
      endfunction

      function void check_response(pixel_type got);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            error_count++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("%0t: response with no request pending: r=%0d g=%0d b=%0d a=%0d",
                        $realtime, got.red, got.green, got.blue, got.alpha);
            end
            return;
         end
         want = pending_pixels.pop_front();
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha) begin
            error_count++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d, ",
                        $realtime, want.red, want.green, want.blue, want.alpha,
                        "got r=%0d g=%0d b=%0d a=%0d",
                        got.red, got.green, got.blue, got.alpha);
            end
         end
      endfunction

      function int pending_count();
         return pending_pixels.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   chan_type csr_data;

   int req_idle_pct = 28;
   int rsp_idle_pct = 77;
   int idle_cycles  = 0;

   pixel_checker pixels = new();

   rtbq_req_if req_bus();
   rtbq_rsp_if rsp_bus();

   rgb_tint_quadratic_blend i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // response back-pressure, redrawn every falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      pixel_type seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen = {req_bus.in_red, req_bus.in_green, req_bus.in_blue, req_bus.in_alpha};
            pixels.note_request(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue, rsp_bus.out_alpha};
            pixels.check_response(seen);
         end
      end
   end

   // hang detection: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one request; called and returns at a falling edge, valid left high
   task automatic send_pixel(pixel_type px);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.in_red   = px.red;
      req_bus.in_green = px.green;
      req_bus.in_blue  = px.blue;
      req_bus.in_alpha = px.alpha;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // stop requests and wait until every response is back
   task automatic drain();
      req_bus.valid = 1'b0;
      while (pixels.pending_count() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // program all three tints while idle, optionally poking the unused index too
   task automatic configure(chan_type red, chan_type green, chan_type blue, bit poke_unused);
      chan_type junk;
      drain();
      csr_wr_en = 1'b1;
      csr_index = CSR_TINT_RED;
      csr_data  = red;
      @(negedge clock);
      pixels.set_tint(CSR_TINT_RED, red);
      csr_index = CSR_TINT_GREEN;
      csr_data  = green;
      @(negedge clock);
      pixels.set_tint(CSR_TINT_GREEN, green);
      csr_index = CSR_TINT_BLUE;
      csr_data  = blue;
      @(negedge clock);
      pixels.set_tint(CSR_TINT_BLUE, blue);
      if (poke_unused) begin
         junk      = chan_type'($urandom_range(0, 255));
         csr_index = CSR_INDEX_UNUSED;
         csr_data  = junk;
         @(negedge clock);
         pixels.set_tint(CSR_INDEX_UNUSED, junk);
      end
      csr_wr_en = 1'b0;
   endtask

   // tints lean toward zero (pass-through) and the extremes
   function automatic chan_type pick_tint();
      unique case ($urandom_range(0, 9))
         0, 1:    return 8'd0;
         2:       return 8'd255;
         3:       return 8'd1;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic chan_type pick_chan();
      if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      return chan_type'($urandom_range(0, 255));
   endfunction

   initial begin
      pixel_type px;
      req_bus.valid    = 1'b0;
      req_bus.in_red   = '0;
      req_bus.in_green = '0;
      req_bus.in_blue  = '0;
      req_bus.in_alpha = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_TINT_RED;
      csr_data         = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset tints are zero: everything passes through
      send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
      send_pixel({8'hAA, 8'h55, 8'h0F, 8'hF0});

      // full tints: largest radicand and pure-tint cases
      configure(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
      send_pixel({8'd0, 8'd128, 8'd255, 8'd7});

      // smallest nonzero tint
      configure(8'd1, 8'd1, 8'd1, 1'b0);
      send_pixel({8'd0, 8'd1, 8'd255, 8'd128});
      send_pixel({8'd255, 8'd0, 8'd2, 8'd1});

      // mixed: one channel bypassed, others blended
      configure(8'd0, 8'd200, 8'd1, 1'b0);
      send_pixel({8'd255, 8'd17, 8'd0, 8'd254});
      send_pixel({8'd1, 8'd255, 8'd99, 8'd0});

      // write to the unused index must not disturb any tint
      configure(8'd17, 8'd0, 8'd99, 1'b1);
      send_pixel({8'd200, 8'd201, 8'd202, 8'd203});
      send_pixel({8'd0, 8'd255, 8'd255, 8'd85});

      // random segments, each with its own tint setting
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 7) begin
            req_idle_pct = 28;
            rsp_idle_pct = 77;
         end else if (seg < 14) begin
            req_idle_pct = 77;
            rsp_idle_pct = 28;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         configure(pick_tint(), pick_tint(), pick_tint(), $urandom_range(0, 3) == 0);
         repeat (SEGMENT_ITEMS) begin
            px.red   = pick_chan();
            px.green = pick_chan();
            px.blue  = pick_chan();
            px.alpha = pick_chan();
            send_pixel(px);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pixels.pending_count() != 0)
         $display("%0d requests never got a response", pixels.pending_count());
      if (pixels.error_count == 0 && pixels.pending_count() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> rgb_tint_quadratic_blend.f
+incdir+rtl/core
rtl/core/rtbq_pkg.sv
rtl/core/rtbq_if.sv
rtl/core/rtbq_ctrl.sv
rtl/core/rtbq_lane.sv
rtl/core/rtbq_merge.sv
rtl/core/rgb_tint_quadratic_blend.sv
rtl/core/rtbq_checker.sv
tb/tb.sv
